>>> rtl/core/cbs_pkg.sv
// Shared types and constants for the codebook cleanup search block.
// Used by cbs_datapath, cbs_ctrl and codebook_cleanup_search; no dependencies.
`default_nettype none

package cbs_pkg;

  // Sizes of the store
  localparam int MaxEntries = 64;
  localparam int MaxLength  = 256;

  // Derived widths
  localparam int IdxW    = $clog2(MaxEntries);
  localparam int CntW    = $clog2(MaxEntries + 1);
  localparam int PosW    = $clog2(MaxLength);
  localparam int CbAddrW = IdxW + PosW;
  localparam int CbDepth = MaxEntries * MaxLength;

  // Field widths
  localparam int ElemW = 16;
  localparam int ProdW = 2 * ElemW;
  localparam int LenW  = 9;
  localparam int SimW  = 40;

  localparam logic [LenW-1:0] LenReset = LenW'(256);
  localparam logic [LenW-1:0] LenMax   = LenW'(MaxLength);
  localparam logic [CntW-1:0] CntFull  = CntW'(MaxEntries);

  localparam logic signed [SimW-1:0] SimMax = {1'b0, {(SimW-1){1'b1}}};
  localparam logic signed [SimW-1:0] SimMin = {1'b1, {(SimW-1){1'b0}}};

  typedef enum logic [1:0] {
    MODE_CLEAR  = 2'd0,
    MODE_ADD    = 2'd1,
    MODE_QUERY  = 2'd2,
    MODE_UNUSED = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_ADDED = 2'd0,
    ST_FULL  = 2'd1,
    ST_DONE  = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DRAIN
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic            accept;
    logic            issue;
    logic [IdxW-1:0] issue_idx;
    logic            load_out;
    status_t         out_status;
  } ctl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    mode_t           mode_eff;
    logic            last;
    logic [CntW-1:0] count;
    logic            full;
    logic            pipe_busy;
    logic            out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

>>> rtl/core/cbs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module cbs_ram #(
  parameter int Width = 16,
  parameter int Depth = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]              rdata
);

  logic [Width-1:0] mem [Depth];

  // Write, then register the read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> rtl/core/cbs_datapath.sv
// Datapath: vector bookkeeping, codebook and accumulator RAMs, MAC pipeline,
// best-match tracking and output register. Depends on cbs_pkg and cbs_ram.
`default_nettype none

module cbs_datapath (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_we,
  input  wire logic [cbs_pkg::LenW-1:0]   cfg_wdata,
  input  wire logic [15:0]                s_tdata,
  input  wire logic [1:0]                 s_tuser,
  output logic                            m_tvalid,
  input  wire logic                       m_tready,
  output logic [47:0]                     m_tdata,
  output logic [1:0]                      m_tuser,
  input  wire cbs_pkg::ctl_cmd_t          cmd,
  output cbs_pkg::dp_stat_t               stat
);
  import cbs_pkg::*;

  logic [LenW-1:0] vector_length;
  logic [LenW-1:0] len_eff;
  logic [PosW-1:0] pos;
  logic [CntW-1:0] count;
  mode_t           vector_mode;
  mode_t           mode_in;
  mode_t           mode_eff;
  logic            first;
  logic            last;
  logic            full;

  // Query element held while its entries are processed
  logic signed [ElemW-1:0] x_q;
  logic [PosW-1:0]         pos_q;
  logic                    zero_acc_q;
  logic                    last_q;

  // Pipeline
  logic                    s1_valid;
  logic [IdxW-1:0]         s1_idx;
  logic                    s2_valid;
  logic [IdxW-1:0]         s2_idx;
  logic signed [ProdW-1:0] prod;
  logic signed [SimW-1:0]  acc2;
  logic signed [SimW:0]    sum_wide;
  logic signed [SimW-1:0]  sum_sat;

  logic [ElemW-1:0] cb_rdata;
  logic [SimW-1:0]  acc_rdata;
  logic             cb_we;

  logic signed [SimW-1:0] lead_sim;
  logic [IdxW-1:0]        lead_idx;

  // Effective length: zero acts as one, clamp at the store length
  always_comb begin
    if (vector_length == '0) begin
      len_eff = LenW'(1);
    end else if (vector_length > LenMax) begin
      len_eff = LenMax;
    end else begin
      len_eff = vector_length;
    end
  end

  assign mode_in  = mode_t'(s_tuser);
  assign first    = (pos == '0);
  assign mode_eff = first ? mode_in : vector_mode;
  assign last     = ((LenW'(pos) + LenW'(1)) >= len_eff);
  assign full     = (count == CntFull);
  assign cb_we    = cmd.accept && (mode_eff == MODE_ADD) && !full;

  // Status to the controller
  always_comb begin
    stat.mode_eff  = mode_eff;
    stat.last      = last;
    stat.count     = count;
    stat.full      = full;
    stat.pipe_busy = s1_valid || s2_valid;
    stat.out_free  = !m_tvalid || m_tready;
  end

  // Track configuration, position, mode and entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      vector_length <= LenReset;
      pos           <= '0;
      count         <= '0;
      vector_mode   <= MODE_CLEAR;
    end else begin
      if (cfg_we) begin
        vector_length <= cfg_wdata;
      end
      if (cmd.accept) begin
        pos <= last ? '0 : pos + PosW'(1);
        if (first) begin
          vector_mode <= mode_in;
        end
        if (first && (mode_in == MODE_CLEAR)) begin
          count <= '0;
        end else if ((mode_eff == MODE_ADD) && last && !full) begin
          count <= count + CntW'(1);
        end
      end
    end
  end

  // Hold the query element for the entry sweep
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      x_q        <= s_tdata;
      pos_q      <= pos;
      zero_acc_q <= first;
      last_q     <= last;
    end
  end

  cbs_ram #(
    .Width(ElemW),
    .Depth(CbDepth)
  ) u_codebook (
    .clk  (clk),
    .we   (cb_we),
    .waddr({count[IdxW-1:0], pos}),
    .wdata(s_tdata),
    .raddr({cmd.issue_idx, pos_q}),
    .rdata(cb_rdata)
  );

  cbs_ram #(
    .Width(SimW),
    .Depth(MaxEntries)
  ) u_acc (
    .clk  (clk),
    .we   (s2_valid),
    .waddr(s2_idx),
    .wdata(sum_sat),
    .raddr(cmd.issue_idx),
    .rdata(acc_rdata)
  );

  // Advance pipeline valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= cmd.issue;
      s2_valid <= s1_valid;
    end
  end

  // Multiply stage; first element of a query starts from zero
  always_ff @(posedge clk) begin
    s1_idx <= cmd.issue_idx;
    s2_idx <= s1_idx;
    prod   <= x_q * $signed(cb_rdata);
    acc2   <= zero_acc_q ? '0 : $signed(acc_rdata);
  end

  // Accumulate with saturation
  always_comb begin
    sum_wide = {acc2[SimW-1], acc2} + (SimW+1)'(prod);
    if (sum_wide[SimW] != sum_wide[SimW-1]) begin
      sum_sat = sum_wide[SimW] ? SimMin : SimMax;
    end else begin
      sum_sat = sum_wide[SimW-1:0];
    end
  end

  // Keep the first of the greatest sums on the last element
  always_ff @(posedge clk) begin
    if (s2_valid && last_q && ((s2_idx == '0) || (sum_sat > lead_sim))) begin
      lead_sim <= sum_sat;
      lead_idx <= s2_idx;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      m_tuser <= cmd.out_status;
      if (cmd.out_status == ST_DONE) begin
        m_tdata <= {2'b00, lead_sim, lead_idx};
      end else begin
        m_tdata <= '0;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/cbs_ctrl.sv
// Controller: accepts requests, sequences the entry sweep of each query
// element and loads results. Depends on cbs_pkg.
`default_nettype none

module cbs_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               s_tvalid,
  output logic                    s_tready,
  input  wire cbs_pkg::dp_stat_t  stat,
  output cbs_pkg::ctl_cmd_t       cmd
);
  import cbs_pkg::*;

  state_t          state;
  state_t          state_next;
  logic [IdxW-1:0] cnt;
  logic [IdxW-1:0] cnt_next;
  logic            report;
  logic            report_next;
  logic            accept;

  assign s_tready = (state == S_IDLE) && stat.out_free;
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      cnt    <= '0;
      report <= 1'b0;
    end else begin
      state  <= state_next;
      cnt    <= cnt_next;
      report <= report_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    report_next    = report;
    cmd.accept     = accept;
    cmd.issue      = 1'b0;
    cmd.issue_idx  = cnt;
    cmd.load_out   = 1'b0;
    cmd.out_status = ST_ADDED;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (stat.mode_eff)
            MODE_ADD: begin
              if (stat.last) begin
                cmd.load_out   = 1'b1;
                cmd.out_status = stat.full ? ST_FULL : ST_ADDED;
              end
            end
            MODE_QUERY: begin
              if (stat.count == '0) begin
                if (stat.last) begin
                  cmd.load_out   = 1'b1;
                  cmd.out_status = ST_EMPTY;
                end
              end else begin
                state_next  = S_RUN;
                cnt_next    = '0;
                report_next = stat.last;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_RUN: begin
        cmd.issue = 1'b1;
        cnt_next  = cnt + IdxW'(1);
        if ((CntW'(cnt) + CntW'(1)) == stat.count) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!stat.pipe_busy) begin
          if (!report) begin
            state_next = S_IDLE;
          end else if (stat.out_free) begin
            cmd.load_out   = 1'b1;
            cmd.out_status = ST_DONE;
            state_next     = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/core/codebook_cleanup_search.sv
// Top level of the codebook cleanup search block.
// Depends on cbs_pkg, cbs_ctrl, cbs_datapath and cbs_ram.
// Usage:
//   Input requests carry one Q1.15 element in s_tdata and a mode in s_tuser.
//   A vector is vector_length requests; the mode of its first request decides
//   it: clear empties the codebook, add appends the vector as a new entry,
//   query computes its dot product with every stored entry.
//   cfg_we/cfg_wdata write vector_length (0 acts as 1, above 256 as 256);
//   write it only while the block is idle.
//   Results: m_tuser carries the status; m_tdata the best index and its
//   saturated 40-bit similarity (zero unless the query completed).
// Timing:
//   Clear, add and empty-codebook query requests are taken one per cycle
//   while the output is free; the add result appears the cycle after the
//   last element. Each query element sweeps all N stored entries through one
//   multiply-accumulate pipeline; the next request is taken only once the
//   sweep drains, and the result follows the final element's sweep.
// Reset clears the codebook count, position and output; vector_length returns
// to 256. While a result waits in the output register and m_tready is low, no
// new request is taken; a stalled receiver holds the result and backs up the input.
`default_nettype none

module codebook_cleanup_search (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [8:0]  cfg_wdata,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,   // [15:0] element_value
  input  wire logic [1:0]  s_tuser,   // [1:0] mode
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [47:0]      m_tdata,   // [5:0] best_index, [45:6] best_similarity
  output logic [1:0]       m_tuser    // [1:0] status
);
  import cbs_pkg::*;

  ctl_cmd_t cmd;
  dp_stat_t stat;

  cbs_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .stat    (stat),
    .cmd     (cmd)
  );

  cbs_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cmd      (cmd),
    .stat     (stat)
  );

endmodule

`default_nettype wire
